// ----- hw/rtl/slt_pkg.sv -----
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants of the source lexer tokenizer
// token kinds, error codes, lexer modes, keyword table and result entry types
// ----------------------------------------------------------------------------
package slt_pkg;

	// lexer modes
	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_IDENT   = 3'd1,
		M_NUMBER  = 3'd2,
		M_COMMENT = 3'd3,
		M_QOPEN   = 3'd4,
		M_ESCAPE  = 3'd5,
		M_QCLOSE  = 3'd6
	} lex_mode_t;

	// token kinds
	localparam logic [3:0] K_LEXEME  = 4'd0;
	localparam logic [3:0] K_IDENT   = 4'd1;
	localparam logic [3:0] K_KW_BASE = 4'd2;
	localparam logic [3:0] K_NUMBER  = 4'd9;
	localparam logic [3:0] K_CHARLIT = 4'd10;
	localparam logic [3:0] K_SINGLE  = 4'd11;
	localparam logic [3:0] K_EOF     = 4'd12;
	localparam logic [3:0] K_ERROR   = 4'd13;

	// error codes
	localparam logic [1:0] E_NONE      = 2'd0;
	localparam logic [1:0] E_EOF_QUOTE = 2'd1;
	localparam logic [1:0] E_BAD_ESC   = 2'd2;
	localparam logic [1:0] E_NO_CLOSE  = 2'd3;

	// characters
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_N      = 8'h6e;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;

	// keyword table, byte i at bit 8i, zero padded
	localparam int KW_COUNT = 7;
	localparam int KW_BYTES = 6;
	localparam logic [8*KW_BYTES-1:0] KW_TEXT [KW_COUNT] = '{
		48'h0000_0066_6564,  // def
		48'h6e72_6574_7865,  // extern
		48'h0000_0000_6669,  // if
		48'h0000_6573_6c65,  // else
		48'h0000_0072_6f66,  // for
		48'h0079_7261_6e75,  // unary
		48'h7972_616e_6962   // binary
	};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd6, 4'd2, 4'd4, 4'd3, 4'd5, 4'd6
	};

	// result queue depth (power of two)
	localparam int RES_DEPTH = 8;
	localparam int RES_AW    = $clog2(RES_DEPTH);
	localparam int RES_CW    = $clog2(RES_DEPTH + 1);

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] ch;
		logic [1:0] err;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    e0;
		result_t    e1;
	} push_t;

	function automatic logic is_alpha(input logic [7:0] c);
		is_alpha = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		is_space = (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
	endfunction

endpackage

// ----- hw/rtl/slt_lex.sv -----
// ----------------------------------------------------------------------------
// slt_lex: lexer state and single-pass token logic
// takes the registered input byte, updates lexer state, emits up to two results
// ----------------------------------------------------------------------------
module slt_lex #(
	parameter int KEYWORD_MAX_LEN = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [7:0]    in_byte,
	input  logic          in_eof,
	output slt_pkg::push_t push
);
	import slt_pkg::*;

	localparam int BW = 8 * KEYWORD_MAX_LEN;
	localparam int LW = $clog2(KEYWORD_MAX_LEN + 2);
	localparam logic [LW-1:0] LEN_MAX = LW'(KEYWORD_MAX_LEN);
	localparam logic [LW-1:0] LEN_SAT = LW'(KEYWORD_MAX_LEN + 1);

	lex_mode_t       mode_q, mode_d;
	logic [BW-1:0]   kbuf_q, kbuf_d;
	logic [LW-1:0]   len_q, len_d;
	logic [7:0]      lit_q, lit_d;

	logic [3:0]      ident_kind;
	logic            a_vld, b_vld, do_idle;
	result_t         a_res, b_res;

	// keyword compare, bytes above the length are zero in the buffer
	always_comb begin
		ident_kind = K_IDENT;
		if (len_q <= LEN_MAX) begin
			for (int k = KW_COUNT - 1; k >= 0; k--) begin
				if (kbuf_q == BW'(KW_TEXT[k]) && len_q == LW'(KW_LEN[k])) begin
					ident_kind = K_KW_BASE + 4'(k);
				end
			end
		end
	end

	always_comb begin
		mode_d  = mode_q;
		kbuf_d  = kbuf_q;
		len_d   = len_q;
		lit_d   = lit_q;
		a_vld   = 1'b0;
		a_res   = '0;
		b_vld   = 1'b0;
		b_res   = '0;
		do_idle = 1'b0;

		case (mode_q)
			M_IDENT: begin
				if (!in_eof && (is_alpha(in_byte) || is_digit(in_byte))) begin
					a_vld      = 1'b1;
					a_res.kind = K_LEXEME;
					a_res.ch   = in_byte;
					if (len_q < LEN_MAX) begin
						kbuf_d[8*len_q +: 8] = in_byte;
						len_d = len_q + LW'(1);
					end else begin
						len_d = LEN_SAT;
					end
				end else begin
					a_vld      = 1'b1;
					a_res.kind = ident_kind;
					do_idle    = 1'b1;
				end
			end
			M_NUMBER: begin
				a_vld = 1'b1;
				if (!in_eof && (is_digit(in_byte) || in_byte == CH_DOT)) begin
					a_res.kind = K_LEXEME;
					a_res.ch   = in_byte;
				end else begin
					a_res.kind = K_NUMBER;
					do_idle    = 1'b1;
				end
			end
			M_COMMENT: begin
				if (in_eof) begin
					do_idle = 1'b1;
				end else if (in_byte == CH_LF || in_byte == CH_CR) begin
					mode_d = M_IDLE;
				end
			end
			M_QOPEN: begin
				if (in_eof) begin
					a_vld      = 1'b1;
					a_res.kind = K_ERROR;
					a_res.err  = E_EOF_QUOTE;
					do_idle    = 1'b1;
				end else if (in_byte == CH_BSLASH) begin
					mode_d = M_ESCAPE;
				end else begin
					lit_d  = in_byte;
					mode_d = M_QCLOSE;
				end
			end
			M_ESCAPE: begin
				mode_d = M_QCLOSE;
				if (in_eof) begin
					a_vld = 1'b1;
				end else begin
					case (in_byte)
						CH_N:      lit_d = CH_LF;
						CH_R:      lit_d = CH_CR;
						CH_T:      lit_d = CH_TAB;
						CH_BSLASH: lit_d = CH_BSLASH;
						CH_QUOTE:  lit_d = CH_QUOTE;
						default:   a_vld = 1'b1;
					endcase
				end
				if (a_vld) begin
					lit_d      = lit_q;
					a_res.kind = K_ERROR;
					a_res.err  = E_BAD_ESC;
					do_idle    = 1'b1;
				end
			end
			M_QCLOSE: begin
				a_vld = 1'b1;
				if (!in_eof && in_byte == CH_QUOTE) begin
					a_res.kind = K_CHARLIT;
					a_res.ch   = lit_q;
					mode_d     = M_IDLE;
				end else begin
					a_res.kind = K_ERROR;
					a_res.err  = E_NO_CLOSE;
					do_idle    = 1'b1;
				end
			end
			default: do_idle = 1'b1;
		endcase

		// lex the byte from idle
		if (do_idle) begin
			mode_d = M_IDLE;
			if (in_eof) begin
				b_vld      = 1'b1;
				b_res.kind = K_EOF;
			end else if (is_space(in_byte)) begin
				b_vld = 1'b0;
			end else if (is_alpha(in_byte)) begin
				b_vld      = 1'b1;
				b_res.kind = K_LEXEME;
				b_res.ch   = in_byte;
				kbuf_d     = BW'(in_byte);
				len_d      = LW'(1);
				mode_d     = M_IDENT;
			end else if (is_digit(in_byte) || in_byte == CH_DOT) begin
				b_vld      = 1'b1;
				b_res.kind = K_LEXEME;
				b_res.ch   = in_byte;
				mode_d     = M_NUMBER;
			end else if (in_byte == CH_QUOTE) begin
				mode_d = M_QOPEN;
			end else if (in_byte == CH_HASH) begin
				mode_d = M_COMMENT;
			end else begin
				b_vld      = 1'b1;
				b_res.kind = K_SINGLE;
				b_res.ch   = in_byte;
			end
		end

		// pack results, last flag on the final one
		push = '0;
		if (in_valid) begin
			if (a_vld && b_vld) begin
				push.cnt     = 2'd2;
				push.e0      = a_res;
				push.e1      = b_res;
				push.e1.last = 1'b1;
			end else if (a_vld) begin
				push.cnt     = 2'd1;
				push.e0      = a_res;
				push.e0.last = 1'b1;
			end else if (b_vld) begin
				push.cnt     = 2'd1;
				push.e0      = b_res;
				push.e0.last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			kbuf_q <= '0;
			len_q  <= '0;
			lit_q  <= '0;
		end else if (in_valid) begin
			mode_q <= mode_d;
			kbuf_q <= kbuf_d;
			len_q  <= len_d;
			lit_q  <= lit_d;
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_SAT)
		else $error("identifier length beyond saturation");

	a_two_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd2 |-> !push.e0.last && push.e1.last)
		else $error("two results with wrong last flags");

	a_two_needs_idle: assert property (@(posedge clk) disable iff (!arst_n)
		push.cnt == 2'd2 |-> push.e0.kind != K_LEXEME && push.e0.kind != K_CHARLIT)
		else $error("second result after a token that keeps its mode");

endmodule

// ----- hw/rtl/slt_fifo.sv -----
// ----------------------------------------------------------------------------
// slt_fifo: result queue
// takes up to two results a cycle, hands out one per beat on the output side
// ----------------------------------------------------------------------------
module slt_fifo (
	input  logic                    clk,
	input  logic                    arst_n,
	input  slt_pkg::push_t          push,
	input  logic                    pop,
	output slt_pkg::result_t        head,
	output logic [slt_pkg::RES_CW-1:0] count
);
	import slt_pkg::*;

	result_t           mem [RES_DEPTH];
	logic [RES_AW-1:0] wr_q, rd_q;
	logic [RES_CW-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[wr_q] <= push.e0;
		end
		if (push.cnt == 2'd2) begin
			mem[wr_q + RES_AW'(1)] <= push.e1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + RES_AW'(push.cnt);
			rd_q    <= rd_q + RES_AW'(pop);
			count_q <= count_q + RES_CW'(push.cnt) - RES_CW'(pop);
		end
	end

	assign head  = mem[rd_q];
	assign count = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(RES_CW + 1)'(count_q) + (RES_CW + 1)'(push.cnt) <= (RES_CW + 1)'(RES_DEPTH))
		else $error("result queue overflow");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty result queue");

endmodule

// ----- hw/rtl/source_lexer_tokenizer_top.sv -----
// ----------------------------------------------------------------------------
// source_lexer_tokenizer_top: streaming source lexer
// one source byte or end mark per input beat, zero to two token beats out
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents
//  --------  ---  ------------------------------------------------------------
//  s_*       in   tdata = byte_in[7:0], tlast = end_of_input
//  m_*       out  tdata = char_value[7:0], error_code[9:8]; tuser = token_kind;
//                 tlast = last result of one input beat
//
//  one input beat per clock while s_tready is high; each beat is registered, lexed in the
//  next cycle and its results land in an eight-entry result queue
//  output rate is one result beat per clock while m_tready is high, so beats that
//  give two results (token end plus next byte) drain as two result beats
//  s_tready holds off while the queue could not take two more results for the
//  beat already in flight and for a new one
//  arst_n clears the lexer to idle, the keyword buffer and the queue
//
module source_lexer_tokenizer_top #(
	parameter int KEYWORD_MAX_LEN = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // byte_in[7:0]
	input  logic        s_tlast,   // end_of_input
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // char_value[7:0], error_code[9:8], zero [15:10]
	output logic [3:0]  m_tuser,   // token_kind[3:0]
	output logic        m_tlast    // last
);
	import slt_pkg::*;

	// input register
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                eof_s1;

	push_t               push;
	result_t             head;
	logic [RES_CW-1:0]   count;
	logic [RES_CW:0]     committed;
	logic                pop;

	// queue slots already spoken for: stored results plus two for the beat in s1
	assign committed = (RES_CW + 1)'(count) + (valid_s1 ? (RES_CW + 1)'(2) : '0);
	assign s_tready  = committed <= (RES_CW + 1)'(RES_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_tvalid && s_tready;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			eof_s1  <= s_tlast;
		end
	end

	slt_lex #(
		.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
	) u_lex (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(valid_s1),
		.in_byte (byte_s1),
		.in_eof  (eof_s1),
		.push    (push)
	);

	assign pop = m_tvalid && m_tready;

	slt_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.head  (head),
		.count (count)
	);

	// output beat straight from the queue head
	assign m_tvalid = count != '0;
	assign m_tdata  = {6'd0, head.err, head.ch};
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;

endmodule
